// ===== src/header_framed_byte_receiver_macros.svh =====
// assertion macros for the receiver port checker
`ifndef HEADER_FRAMED_BYTE_RECEIVER_MACROS_SVH
`define HEADER_FRAMED_BYTE_RECEIVER_MACROS_SVH

// same-cycle implication, disabled during reset
`define HFBR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define HFBR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hfbr_pkg.sv =====
// types and constants shared by the receiver modules
package hfbr_pkg;

    localparam int OUT_LIMIT = 32;

    localparam logic [7:0]  HEADER_RESET    = 8'hff;
    localparam logic [5:0]  FRAME_LEN_RESET = 6'd20;
    localparam logic [15:0] IDLE_RESET      = 16'd50;

    typedef enum logic [1:0] {
        REG_HEADER    = 2'd0,
        REG_FRAME_LEN = 2'd1,
        REG_IDLE      = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic {
        REASON_FULL = 1'b0,
        REASON_IDLE = 1'b1
    } reason_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_LOAD = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic step;
        logic rd_issue;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== src/hfbr_ctrl.sv =====
// controller state machine: input acceptance and frame emission sequencing
module hfbr_ctrl import hfbr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.step = s_tvalid;
                if (s_tvalid && status.emit) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LOAD;
            end
            ST_LOAD: begin
                // wait for the output register to free up
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = status.last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/hfbr_datapath.sv =====
// datapath: config registers, header/timer state, frame store and output register
module hfbr_datapath import hfbr_pkg::*; #(
    parameter int MAX_FRAME = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    localparam int LEN_MAX = (MAX_FRAME < OUT_LIMIT) ? MAX_FRAME : OUT_LIMIT;
    localparam int AW      = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam logic [5:0] LEN_MAX_W = 6'(LEN_MAX);
    localparam logic [8:0] DEPTH_W   = 9'(MAX_FRAME);

    // configuration
    logic [7:0]  header_reg, header_next;
    logic [5:0]  flen_reg, flen_next;
    logic [15:0] idle_to_reg, idle_to_next;

    // receive state
    logic [1:0]  run_reg, run_next;
    logic        collecting_reg, collecting_next;
    logic [5:0]  fill_reg, fill_next;
    logic [15:0] idle_cnt_reg, idle_cnt_next;
    logic        running_reg, running_next;

    // emission state
    logic [5:0]  len_cap_reg, len_cap_next;
    logic [5:0]  real_reg, real_next;
    logic        reason_reg, reason_next;
    logic [4:0]  rd_idx_reg, rd_idx_next;
    logic [7:0]  rd_data_reg;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [4:0]  out_idx_reg, out_idx_next;
    logic        out_reason_reg, out_reason_next;
    logic [5:0]  out_count_reg, out_count_next;
    logic        out_last_reg, out_last_next;

    logic [7:0]  store_mem [MAX_FRAME];

    logic [5:0]  eff_len;
    logic        is_tick;
    logic        tick_expire;
    logic [5:0]  fill_inc;
    logic [1:0]  run_new;
    logic        hdr_seen;
    logic [5:0]  fill_after;
    logic        emit;
    logic [5:0]  real_src;
    logic [5:0]  real_new;
    logic [8:0]  fill_ext;
    logic [8:0]  rd_ext;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    always_comb begin
        if (flen_reg == 6'd0) begin
            eff_len = 6'd1;
        end else if (flen_reg > LEN_MAX_W) begin
            eff_len = LEN_MAX_W;
        end else begin
            eff_len = flen_reg;
        end
    end

    always_comb begin
        is_tick     = (cmd_t'(s_tuser) == CMD_TICK);
        tick_expire = running_reg && (idle_cnt_reg <= 16'd1);
        if (collecting_reg && (fill_reg != 6'd63)) begin
            fill_inc = fill_reg + 6'd1;
        end else begin
            fill_inc = fill_reg;
        end
        if (s_tdata == header_reg) begin
            run_new = (run_reg == 2'd3) ? run_reg : run_reg + 2'd1;
        end else begin
            run_new = 2'd0;
        end
        // the second header byte in a row restarts the frame
        hdr_seen   = (run_new == 2'd2);
        fill_after = hdr_seen ? 6'd0 : fill_inc;
        emit       = is_tick ? tick_expire : (fill_after >= eff_len);
        real_src   = is_tick ? fill_reg : fill_after;
        real_new   = (real_src > eff_len) ? eff_len : real_src;
        fill_ext   = 9'(fill_reg);
        wr_en      = cmd.step && !is_tick && collecting_reg && (fill_ext < DEPTH_W);
        wr_addr    = fill_ext[AW-1:0];
        rd_ext     = 9'(rd_idx_reg);
        rd_addr    = rd_ext[AW-1:0];
    end

    assign status.emit     = emit;
    assign status.last     = ({1'b0, rd_idx_reg} == (len_cap_reg - 6'd1));
    assign status.out_free = !m_valid_reg || m_tready;

    always_comb begin
        header_next     = header_reg;
        flen_next       = flen_reg;
        idle_to_next    = idle_to_reg;
        run_next        = run_reg;
        collecting_next = collecting_reg;
        fill_next       = fill_reg;
        idle_cnt_next   = idle_cnt_reg;
        running_next    = running_reg;
        len_cap_next    = len_cap_reg;
        real_next       = real_reg;
        reason_next     = reason_reg;
        rd_idx_next     = rd_idx_reg;
        m_valid_next    = m_valid_reg;
        out_byte_next   = out_byte_reg;
        out_idx_next    = out_idx_reg;
        out_reason_next = out_reason_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;

        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_HEADER:    header_next  = cfg_data[7:0];
                REG_FRAME_LEN: flen_next    = cfg_data[5:0];
                REG_IDLE:      idle_to_next = cfg_data;
                default: ;
            endcase
        end

        if (cmd.step) begin
            if (is_tick) begin
                if (running_reg) begin
                    if (tick_expire) begin
                        idle_cnt_next = 16'd0;
                        running_next  = 1'b0;
                    end else begin
                        idle_cnt_next = idle_cnt_reg - 16'd1;
                    end
                end
            end else begin
                idle_cnt_next = idle_to_reg;
                running_next  = 1'b1;
                run_next      = run_new;
                fill_next     = fill_after;
                if (hdr_seen) begin
                    collecting_next = 1'b1;
                end
            end
            if (emit) begin
                fill_next    = 6'd0;
                len_cap_next = eff_len;
                real_next    = real_new;
                reason_next  = is_tick ? REASON_IDLE : REASON_FULL;
                rd_idx_next  = 5'd0;
            end
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load) begin
            m_valid_next    = 1'b1;
            // zero padding past the real bytes
            out_byte_next   = ({1'b0, rd_idx_reg} < real_reg) ? rd_data_reg : 8'd0;
            out_idx_next    = rd_idx_reg;
            out_reason_next = reason_reg;
            out_count_next  = real_reg;
            out_last_next   = status.last;
            rd_idx_next     = rd_idx_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg     <= HEADER_RESET;
            flen_reg       <= FRAME_LEN_RESET;
            idle_to_reg    <= IDLE_RESET;
            run_reg        <= 2'd0;
            collecting_reg <= 1'b0;
            fill_reg       <= 6'd0;
            idle_cnt_reg   <= IDLE_RESET;
            running_reg    <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            header_reg     <= header_next;
            flen_reg       <= flen_next;
            idle_to_reg    <= idle_to_next;
            run_reg        <= run_next;
            collecting_reg <= collecting_next;
            fill_reg       <= fill_next;
            idle_cnt_reg   <= idle_cnt_next;
            running_reg    <= running_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_cap_reg    <= len_cap_next;
        real_reg       <= real_next;
        reason_reg     <= reason_next;
        rd_idx_reg     <= rd_idx_next;
        out_byte_reg   <= out_byte_next;
        out_idx_reg    <= out_idx_next;
        out_reason_reg <= out_reason_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    // entries below the fill count are always written after the last restart
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= s_tdata;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, out_count_reg, out_idx_reg, out_byte_reg};
    assign m_tuser  = out_reason_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/header_framed_byte_receiver.sv =====
// header-framed byte receiver with idle timeout: top level
//
// s_ channel: one event per request. s_tuser = 0 carries a received byte in
// s_tdata, s_tuser = 1 is a one millisecond tick (s_tdata ignored).
// m_ channel: one request per emitted frame byte; m_tlast marks the final
// byte, m_tuser gives the close reason (0 full, 1 idle timeout).
// cfg channel: cfg_index 0 header byte, 1 frame length, 2 idle timeout in
// ticks; other indexes are ignored. cfg_ready is always high.
// An event that closes no frame is taken without leaving idle, so such
// events can arrive back to back. An event that closes a frame starts
// emission of frame-length bytes, each byte passing a registered frame
// store read, then an output register load. s_tready is low during
// emission.
// A low m_tready holds the current byte in the output register and halts
// emission; after the final byte is loaded, new events are taken even while
// it waits. Reset restores register defaults, starts the idle timer and
// needs no clearing pass.
module header_framed_byte_receiver import hfbr_pkg::*; #(
    parameter int MAX_FRAME = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // frame_byte[7:0], byte_index[12:8], stored_count[18:13]
    output logic        m_tuser,   // close_reason
    output logic        m_tlast
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    hfbr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hfbr_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== src/hfbr_checker.sv =====
// port-level checker for the receiver, bound to the top level
`include "header_framed_byte_receiver_macros.svh"

module hfbr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [15:0] cfg_data,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    logic [4:0] exp_idx_reg, exp_idx_next;

    // byte index expected on the next result
    always_comb begin
        exp_idx_next = exp_idx_reg;
        if (m_tvalid && m_tready) begin
            exp_idx_next = m_tlast ? 5'd0 : m_tdata[12:8] + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_idx_reg <= 5'd0;
        end else begin
            exp_idx_reg <= exp_idx_next;
        end
    end

    `HFBR_ASSERT_NOW(a_idx_seq, m_tvalid, m_tdata[12:8] == exp_idx_reg, "byte index out of sequence")
    `HFBR_ASSERT_NOW(a_pad_zero, m_tvalid && ({1'b0, m_tdata[12:8]} >= m_tdata[18:13]), m_tdata[7:0] == 8'd0, "nonzero padding byte")
    `HFBR_ASSERT_NOW(a_count_bound, m_tvalid && m_tlast, m_tdata[18:13] <= ({1'b0, m_tdata[12:8]} + 6'd1), "stored count exceeds frame length")
    `HFBR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind header_framed_byte_receiver hfbr_checker u_hfbr_checker (.*);

// ===== tb/hfbr_checker.sv =====
// frame byte predictor and result comparison for the header-framed receiver
`timescale 1ns / 1ps

module hfbr_frame_checker import hfbr_pkg::*; #(
    parameter int MAX_FRAME = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  logic        s_tuser,   // cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // frame_byte[7:0], byte_index[12:8], stored_count[18:13]
    input  logic        m_tuser,   // close_reason
    input  logic        m_tlast,
    output int          failures,
    output int          bytes_due
);

    typedef struct packed {
        logic [7:0] value;
        logic [4:0] index;
        reason_t    reason;
        logic [5:0] held;
        logic       last;
    } frame_beat_t;

    frame_beat_t frame_bytes_due[$];
    int          fail_count = 0;
    int          due_count  = 0;

    // register copies
    logic [7:0]  hdr_byte;
    logic [5:0]  frame_len;
    logic [15:0] idle_reload;

    // receiver state
    logic [1:0]  header_run;
    logic        collecting;
    logic [5:0]  fill;
    logic [7:0]  store [MAX_FRAME];
    logic [15:0] idle_left;
    logic        timer_on;

    assign failures  = fail_count;
    assign bytes_due = due_count;

    function automatic int eff_len();
        int n;
        n = frame_len;
        if (n < 1) n = 1;
        if (n > MAX_FRAME) n = MAX_FRAME;
        if (n > OUT_LIMIT) n = OUT_LIMIT;
        return n;
    endfunction

    function automatic void close_frame(reason_t why);
        int          len;
        int          kept;
        frame_beat_t beat;
        len  = eff_len();
        kept = (fill > len) ? len : fill;
        for (int i = 0; i < len; i++) begin
            beat.value  = (i < kept && i < MAX_FRAME) ? store[i] : 8'h00;
            beat.index  = 5'(i);
            beat.reason = why;
            beat.held   = 6'(kept);
            beat.last   = (i + 1 == len);
            frame_bytes_due.push_back(beat);
        end
        fill = '0;
    endfunction

    function automatic void take_event(cmd_t cmd, logic [7:0] rx);
        if (cmd == CMD_TICK) begin
            if (!timer_on) return;
            if (idle_left <= 16'd1) begin
                idle_left = '0;
                timer_on  = 1'b0;
                close_frame(REASON_IDLE);
            end else begin
                idle_left = idle_left - 16'd1;
            end
            return;
        end
        idle_left = idle_reload;
        timer_on  = 1'b1;
        if (collecting) begin
            if (fill < MAX_FRAME) store[fill] = rx;
            if (fill < 6'd63) fill = fill + 6'd1;
        end
        if (rx == hdr_byte) begin
            if (header_run < 2'd3) header_run = header_run + 2'd1;
        end else begin
            header_run = '0;
        end
        // the second header byte was just stored and is wiped here with the rest
        if (header_run == 2'd2) begin
            collecting = 1'b1;
            fill       = '0;
            foreach (store[i]) store[i] = '0;
        end
        if (fill >= eff_len()) close_frame(REASON_FULL);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        frame_beat_t beat;
        if (!aresetn) begin
            frame_bytes_due.delete();
            hdr_byte    = HEADER_RESET;
            frame_len   = FRAME_LEN_RESET;
            idle_reload = IDLE_RESET;
            header_run  = '0;
            collecting  = 1'b0;
            fill        = '0;
            foreach (store[i]) store[i] = '0;
            idle_left   = IDLE_RESET;
            timer_on    = 1'b1;
        end else begin
            // results first: a request taken at this edge shows its bytes later
            if (m_tvalid && m_tready) begin
                if (frame_bytes_due.size() == 0) begin
                    $error("frame_byte %0d arrived with no frame due", m_tdata[7:0]);
                    fail_count++;
                end else begin
                    beat = frame_bytes_due.pop_front();
                    check_field("frame_byte", beat.value, m_tdata[7:0]);
                    check_field("byte_index", beat.index, m_tdata[12:8]);
                    check_field("stored_count", beat.held, m_tdata[18:13]);
                    check_field("close_reason", beat.reason, m_tuser);
                    check_field("frame_last", beat.last, m_tlast);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HEADER:    hdr_byte    = cfg_data[7:0];
                    REG_FRAME_LEN: frame_len   = cfg_data[5:0];
                    REG_IDLE:      idle_reload = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) take_event(cmd_t'(s_tuser), s_tdata);
        end
        due_count = frame_bytes_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
// stimulus, clock, reset and verdict for the header-framed byte receiver
`timescale 1ns / 1ps

module testbench;
    import hfbr_pkg::*;

    localparam logic [1:0] REG_NONE    = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT = 400000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int          failures;
    int          bytes_due;
    int          cycle_count = 0;

    logic        steady      = 1'b0;
    logic        hold_armed  = 1'b0;
    logic        hold_done   = 1'b0;
    int          hold_left   = 0;

    logic [7:0]  cur_hdr  = 8'hff;
    int          cur_len  = 20;
    int          cur_idle = 50;

    header_framed_byte_receiver u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    hfbr_frame_checker u_frame_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .failures  (failures),
        .bytes_due (bytes_due)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // frame byte sink: random stalls, one long hold-off while requests keep coming
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_armed && !hold_done && m_tvalid) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= steady || ($urandom_range(99) >= 20);
        end
    end

    task automatic send_event(input cmd_t cmd, input logic [7:0] rx);
        while (!steady && $urandom_range(99) < 20) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_byte(input logic [7:0] rx);
        send_event(CMD_BYTE, rx);
    endtask

    task automatic send_tick();
        send_event(CMD_TICK, 8'($urandom));
    endtask

    // wait for every frame byte due, then let the block settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (bytes_due != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_phase(input logic [7:0] hdr, input logic [5:0] len,
                                 input logic [15:0] idle);
        drain();
        write_reg(REG_HEADER, {8'($urandom), hdr});
        write_reg(REG_FRAME_LEN, {10'($urandom), len});
        write_reg(REG_IDLE, idle);
        if ($urandom_range(1) == 1) write_reg(REG_NONE, 16'($urandom));
        cur_hdr  = hdr;
        cur_len  = (len == 0) ? 1 : (len > 32) ? 32 : int'(len);
        cur_idle = idle;
    endtask

    // mostly header pairs followed by data and ticks, the rest noise
    task automatic random_traffic(input int n_items);
        int sent;
        int nb;
        int nt;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 75) begin
                send_byte(cur_hdr);
                send_byte(cur_hdr);
                nb = $urandom_range(cur_len + 3);
                repeat (nb) send_byte(($urandom_range(7) == 0) ? cur_hdr : 8'($urandom));
                nt = (cur_idle <= 60) ? $urandom_range(cur_idle + 1) : $urandom_range(4);
                repeat (nt) send_tick();
                sent += nb + 2 + nt;
            end else begin
                case ($urandom_range(2))
                    0: begin
                        send_tick();
                        sent++;
                    end
                    1: begin
                        // broken header
                        send_byte(cur_hdr);
                        send_byte(8'($urandom));
                        sent += 2;
                    end
                    default: begin
                        send_byte(8'($urandom));
                        sent++;
                    end
                endcase
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // the reset timer keeps its count of 50, new timeout only on reload
        write_reg(REG_IDLE, 16'd1);
        write_reg(REG_HEADER, 16'h00a5);
        write_reg(REG_FRAME_LEN, 16'd4);
        write_reg(REG_NONE, 16'hffff);
        send_tick();
        send_byte(8'h00);
        send_tick();               // all-zero frame on timeout
        send_tick();               // timer stopped
        send_byte(8'ha5);
        send_byte(8'ha5);
        send_byte(8'ha5);          // third header in a row kept as data
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h7e);          // frame full
        send_byte(8'h12);
        send_tick();               // partial frame on timeout
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        drain();
        write_reg(REG_FRAME_LEN, 16'd2);   // below the current fill
        send_byte(8'h04);
        drain();
        write_reg(REG_FRAME_LEN, 16'd0);   // acts as one
        send_byte(8'h80);
        drain();
        write_reg(REG_FRAME_LEN, 16'hffff);
        write_reg(REG_IDLE, 16'd0);
        send_byte(8'h55);
        send_tick();
        send_tick();

        program_phase(8'($urandom), 6'd1, 16'd1);
        random_traffic(20);
        program_phase(8'h00, 6'd32, 16'd3);
        random_traffic(30);
        program_phase(8'hff, 6'd63, 16'hffff);
        random_traffic(30);
        program_phase(8'($urandom), 6'($urandom_range(2, 8)), 16'($urandom_range(1, 6)));
        hold_armed <= 1'b1;
        random_traffic(30);
        program_phase(8'($urandom), 6'd20, 16'd50);
        steady <= 1'b1;
        random_traffic(25);
        drain();
        steady <= 1'b0;
        program_phase(8'($urandom), 6'd5, 16'd0);
        random_traffic(20);

        drain();
        repeat (20) @(posedge aclk);
        if (failures == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
